// ----- src/rwb_pkg.sv -----
package rwb_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned ROB_DEPTH = 32;

  localparam int unsigned IN_TDATA_W  = 384;
  localparam int unsigned OUT_TDATA_W = 288;

  localparam logic [63:0] XMASK = 64'({XLEN{1'b1}});

  localparam logic [6:0]  OP_CSR    = 7'h73;
  localparam logic [6:0]  OP_JAL    = 7'h6F;
  localparam logic [6:0]  OP_JALR   = 7'h67;
  localparam logic [6:0]  OP_BRANCH = 7'h63;
  localparam logic [11:0] FCSR_ADDR = 12'h003;

  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  localparam logic [1:0] CSR_OP_NONE = 2'b00;
  localparam logic [1:0] CSR_OP_RW   = 2'b01;
  localparam logic [1:0] CSR_OP_RS   = 2'b10;

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_INT  = 2'd1;
  localparam logic [1:0] WK_FP   = 2'd2;

  localparam int unsigned FL_ILLEGAL = 0;
  localparam int unsigned FL_BRANCH  = 1;
  localparam int unsigned FL_REGWR   = 2;
  localparam int unsigned FL_TOFP    = 3;
  localparam int unsigned FL_FROMMEM = 4;
  localparam int unsigned FL_PRED    = 5;
  localparam int unsigned FL_FCSR    = 6;

  typedef struct packed {
    logic [6:0]  control_flags;
    logic [6:0]  major_opcode;
    logic [2:0]  sub_function;
    logic [4:0]  dest_reg;
    logic [63:0] alu_result;
    logic [63:0] mem_data;
    logic [63:0] instr_pc;
    logic signed [31:0] branch_offset;
    logic [4:0]  reorder_index;
    logic [11:0] csr_address;
    logic [63:0] csr_old;
    logic [63:0] csr_operand;
  } item_t;

  typedef struct packed {
    logic [1:0]  write_kind;
    logic [4:0]  write_reg;
    logic [63:0] write_value;
    logic        csr_write;
    logic [11:0] csr_write_addr;
    logic [63:0] csr_write_value;
    logic        redirect;
    logic [63:0] redirect_pc;
    logic        btb_taken;
    logic [63:0] btb_target;
    logic [4:0]  flush_after;
    logic        is_branch;
  } result_t;

  typedef struct packed {
    logic retire;
    logic branch;
    logic mispredict;
  } cnt_ev_t;

  function automatic logic [4:0] rob_slot(input logic [4:0] s);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (s == 5'(i)) r = 5'(i % ROB_DEPTH);
    end
    return r;
  endfunction

endpackage

// ----- src/rwb_resolve.sv -----
module rwb_resolve
  import rwb_pkg::*;
(
  input  item_t   item_i,
  output result_t res_o,
  output cnt_ev_t ev_o
);

  logic [63:0] off_ext;
  logic [63:0] seq_pc;
  logic [63:0] tgt_pc;
  logic [63:0] csr_nv;
  logic        csr_wr;
  logic        pred;
  logic        taken;
  logic        is_jump;
  logic [63:0] data;

  assign off_ext = {{32{item_i.branch_offset[31]}}, item_i.branch_offset};
  assign seq_pc  = (item_i.instr_pc + 64'd4) & XMASK;
  assign tgt_pc  = (item_i.instr_pc + off_ext) & XMASK;
  assign pred    = item_i.control_flags[FL_PRED];
  assign is_jump = (item_i.major_opcode == OP_JAL) || (item_i.major_opcode == OP_JALR);

  always_comb begin
    case (item_i.sub_function) inside
      F3_BEQ, F3_BGE, F3_BGEU: taken = (item_i.alu_result == 64'd0);
      F3_BNE:                  taken = (item_i.alu_result != 64'd0);
      F3_BLT, F3_BLTU:         taken = (item_i.alu_result == 64'd1);
      default:                 taken = 1'b0;
    endcase
  end

  always_comb begin
    case (item_i.sub_function[1:0])
      CSR_OP_RW: begin
        csr_nv = item_i.csr_operand;
        csr_wr = 1'b1;
      end
      CSR_OP_RS: begin
        csr_nv = item_i.csr_old | item_i.csr_operand;
        csr_wr = (item_i.csr_operand != 64'd0);
      end
      default: begin
        csr_nv = item_i.csr_old & ~item_i.csr_operand;
        csr_wr = (item_i.csr_operand != 64'd0);
      end
    endcase
  end

  always_comb begin
    res_o = '0;
    ev_o  = '0;
    data  = item_i.alu_result;
    if (!item_i.control_flags[FL_ILLEGAL]) begin
      ev_o.retire = 1'b1;
      if (item_i.major_opcode == OP_CSR) begin
        if (item_i.sub_function[1:0] != CSR_OP_NONE) begin
          res_o.write_kind  = WK_INT;
          res_o.write_reg   = item_i.dest_reg;
          res_o.write_value = item_i.csr_old;
          if (csr_wr) begin
            res_o.csr_write       = 1'b1;
            res_o.csr_write_addr  = item_i.csr_address;
            res_o.csr_write_value = csr_nv;
          end
        end
      end else begin
        if (item_i.control_flags[FL_FCSR]) begin
          res_o.csr_write       = 1'b1;
          res_o.csr_write_addr  = FCSR_ADDR;
          res_o.csr_write_value = item_i.csr_operand;
        end
        if (item_i.control_flags[FL_BRANCH]) begin
          ev_o.branch     = 1'b1;
          res_o.is_branch = 1'b1;
          if (is_jump) begin
            data = seq_pc;
            if (!pred) begin
              res_o.redirect    = 1'b1;
              res_o.btb_taken   = 1'b1;
              res_o.redirect_pc = (item_i.major_opcode == OP_JALR) ?
                                  (item_i.alu_result & XMASK) : tgt_pc;
              res_o.btb_target  = res_o.redirect_pc;
            end
          end else if (item_i.major_opcode == OP_BRANCH) begin
            if (taken && !pred) begin
              res_o.redirect    = 1'b1;
              res_o.redirect_pc = tgt_pc;
              res_o.btb_taken   = 1'b1;
              res_o.btb_target  = tgt_pc;
            end else if (!taken && pred) begin
              res_o.redirect    = 1'b1;
              res_o.redirect_pc = seq_pc;
              res_o.btb_target  = tgt_pc;
            end
          end
          if (res_o.redirect) begin
            ev_o.mispredict   = 1'b1;
            res_o.flush_after = rob_slot(item_i.reorder_index);
          end
        end
        if (item_i.control_flags[FL_REGWR]) begin
          res_o.write_kind  = item_i.control_flags[FL_TOFP] ? WK_FP : WK_INT;
          res_o.write_reg   = item_i.dest_reg;
          res_o.write_value = item_i.control_flags[FL_FROMMEM] ? item_i.mem_data : data;
        end
      end
    end
  end

endmodule

// ----- src/rwb_counters.sv -----
module rwb_counters
  import rwb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  cnt_ev_t ev_i
);

  logic [63:0] retired_q, retired_d;
  logic [63:0] branch_q, branch_d;
  logic [63:0] mispredict_q, mispredict_d;

  assign retired_d    = retired_q + 64'(ev_i.retire);
  assign branch_d     = branch_q + 64'(ev_i.branch);
  assign mispredict_d = mispredict_q + 64'(ev_i.mispredict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retired_q    <= '0;
      branch_q     <= '0;
      mispredict_q <= '0;
    end else if (en_i) begin
      retired_q    <= retired_d;
      branch_q     <= branch_d;
      mispredict_q <= mispredict_d;
    end
  end

endmodule

// ----- src/riscv_writeback_branch_resolve.sv -----
// Channel  | Dir | Transfer when               | Payload
// s_axis   | in  | s_axis_tvalid & tready      | tuser control_flags, tdata rest of item
// m_axis   | out | m_axis_tvalid & tready      | tuser write_kind, tdata rest of result
// One result per item; each item passes the input register and then the result register.
// Input register feeds the resolve logic, result register drives m_axis.
// An item may transfer every cycle; a stalled output holds both stages.
// rst_ni clears both valid flags and the retire/branch/mispredict counters.
module riscv_writeback_branch_resolve
  import rwb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [6:0] control_flags
  input  logic [6:0]             s_axis_tuser,
  // [6:0] major_opcode, [9:7] sub_function, [14:10] dest_reg, [78:15] alu_result,
  // [142:79] mem_data, [206:143] instr_pc, [238:207] branch_offset,
  // [243:239] reorder_index, [255:244] csr_address, [319:256] csr_old,
  // [383:320] csr_operand
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] write_kind
  output logic [1:0]             m_axis_tuser,
  // [4:0] write_reg, [68:5] write_value, [69] csr_write, [81:70] csr_write_addr,
  // [145:82] csr_write_value, [146] redirect, [210:147] redirect_pc,
  // [211] btb_taken, [275:212] btb_target, [280:276] flush_after,
  // [281] is_branch, [287:282] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    in_valid_q;
  item_t   item_q, item_d;
  logic    out_valid_q;
  result_t res_q, res_d;
  cnt_ev_t ev;
  logic    out_free;
  logic    adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign item_d.control_flags = s_axis_tuser;
  assign item_d.major_opcode  = s_axis_tdata[6:0];
  assign item_d.sub_function  = s_axis_tdata[9:7];
  assign item_d.dest_reg      = s_axis_tdata[14:10];
  assign item_d.alu_result    = s_axis_tdata[78:15];
  assign item_d.mem_data      = s_axis_tdata[142:79];
  assign item_d.instr_pc      = s_axis_tdata[206:143];
  assign item_d.branch_offset = s_axis_tdata[238:207];
  assign item_d.reorder_index = s_axis_tdata[243:239];
  assign item_d.csr_address   = s_axis_tdata[255:244];
  assign item_d.csr_old       = s_axis_tdata[319:256];
  assign item_d.csr_operand   = s_axis_tdata[383:320];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_q <= item_d;
    if (adv) res_q <= res_d;
  end

  rwb_resolve u_resolve (
    .item_i (item_q),
    .res_o  (res_d),
    .ev_o   (ev)
  );

  rwb_counters u_counters (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ev_i   (ev)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.write_kind;
  assign m_axis_tdata  = {6'd0,
                          res_q.is_branch,
                          res_q.flush_after,
                          res_q.btb_target,
                          res_q.btb_taken,
                          res_q.redirect_pc,
                          res_q.redirect,
                          res_q.csr_write_value,
                          res_q.csr_write_addr,
                          res_q.csr_write,
                          res_q.write_value,
                          res_q.write_reg};

  a_redirect_is_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.redirect |-> res_q.is_branch)
    else $error("redirect without branch");

  a_flush_only_on_redirect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_q.redirect |-> res_q.flush_after == '0 && !res_q.btb_taken)
    else $error("flush or btb data without redirect");

  a_write_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_q.write_kind == WK_NONE || res_q.write_kind == WK_INT ||
                      res_q.write_kind == WK_FP)
    else $error("bad write kind");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("result stage not loaded");

endmodule

// ----- tb/testbench.sv -----
module testbench
  import rwb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SHOW_ERRORS  = 10;

  localparam logic [1:0] CSR_OP_RC = 2'b11;

  localparam logic [6:0] F_ILL  = 7'(1 << FL_ILLEGAL);
  localparam logic [6:0] F_BR   = 7'(1 << FL_BRANCH);
  localparam logic [6:0] F_WR   = 7'(1 << FL_REGWR);
  localparam logic [6:0] F_FP   = 7'(1 << FL_TOFP);
  localparam logic [6:0] F_MEM  = 7'(1 << FL_FROMMEM);
  localparam logic [6:0] F_PRED = 7'(1 << FL_PRED);
  localparam logic [6:0] F_FCSR = 7'(1 << FL_FCSR);

  class writeback_checker;
    result_t     pending_writebacks[$];
    logic [63:0] retired;
    logic [63:0] branches;
    logic [63:0] mispredicts;
    int          errors;
    int          compared;
    int          redirects;
    int          csr_writes;

    function new();
      retired     = '0;
      branches    = '0;
      mispredicts = '0;
      errors      = 0;
      compared    = 0;
      redirects   = 0;
      csr_writes  = 0;
    endfunction

    function int pending();
      return pending_writebacks.size();
    endfunction

    function result_t resolve_writeback(item_t it);
      result_t     r;
      logic [63:0] data, seq, tgt, off64, jt, nv;
      logic        pred, taken, wr;
      r = '0;
      if (it.control_flags[FL_ILLEGAL]) return r;
      retired++;
      if (it.major_opcode == OP_CSR) begin
        if (it.sub_function[1:0] != CSR_OP_NONE) begin
          case (it.sub_function[1:0])
            CSR_OP_RW: begin
              nv = it.csr_operand;
              wr = 1'b1;
            end
            CSR_OP_RS: begin
              nv = it.csr_old | it.csr_operand;
              wr = (it.csr_operand != '0);
            end
            default: begin
              nv = it.csr_old & ~it.csr_operand;
              wr = (it.csr_operand != '0);
            end
          endcase
          r.write_kind  = WK_INT;
          r.write_reg   = it.dest_reg;
          r.write_value = it.csr_old;
          if (wr) begin
            r.csr_write       = 1'b1;
            r.csr_write_addr  = it.csr_address;
            r.csr_write_value = nv;
          end
        end
        return r;
      end
      data = it.alu_result;
      if (it.control_flags[FL_FCSR]) begin
        r.csr_write       = 1'b1;
        r.csr_write_addr  = FCSR_ADDR;
        r.csr_write_value = it.csr_operand;
      end
      if (it.control_flags[FL_BRANCH]) begin
        pred  = it.control_flags[FL_PRED];
        off64 = {{32{it.branch_offset[31]}}, it.branch_offset};
        seq   = (it.instr_pc + 64'd4) & XMASK;
        tgt   = (it.instr_pc + off64) & XMASK;
        branches++;
        r.is_branch = 1'b1;
        if (it.major_opcode == OP_JAL || it.major_opcode == OP_JALR) begin
          data = seq;
          if (!pred) begin
            jt = (it.major_opcode == OP_JALR) ? (it.alu_result & XMASK) : tgt;
            r.redirect    = 1'b1;
            r.redirect_pc = jt;
            r.btb_taken   = 1'b1;
            r.btb_target  = jt;
          end
        end else if (it.major_opcode == OP_BRANCH) begin
          case (it.sub_function)
            F3_BEQ, F3_BGE, F3_BGEU: taken = (it.alu_result == '0);
            F3_BNE:                  taken = (it.alu_result != '0);
            F3_BLT, F3_BLTU:         taken = (it.alu_result == 64'd1);
            default:                 taken = 1'b0;
          endcase
          if (taken && !pred) begin
            r.redirect    = 1'b1;
            r.redirect_pc = tgt;
            r.btb_taken   = 1'b1;
            r.btb_target  = tgt;
          end else if (!taken && pred) begin
            r.redirect    = 1'b1;
            r.redirect_pc = seq;
            r.btb_taken   = 1'b0;
            r.btb_target  = tgt;
          end
        end
        if (r.redirect) begin
          mispredicts++;
          r.flush_after = 5'(it.reorder_index % ROB_DEPTH);
        end
      end
      if (it.control_flags[FL_REGWR]) begin
        r.write_kind  = it.control_flags[FL_TOFP] ? WK_FP : WK_INT;
        r.write_reg   = it.dest_reg;
        r.write_value = it.control_flags[FL_FROMMEM] ? it.mem_data : data;
      end
      return r;
    endfunction

    function void note_input(item_t it);
      pending_writebacks.push_back(resolve_writeback(it));
    endfunction

    function bit differs(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a && errors < SHOW_ERRORS)
        $display("  result %0d %s: expected %h, got %h", compared, name, e, a);
      return (e !== a);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      bit      bad;
      if (pending_writebacks.size() == 0) begin
        if (errors < SHOW_ERRORS) $display("  result with no instruction outstanding");
        errors++;
        return;
      end
      exp_r = pending_writebacks.pop_front();
      bad = 1'b0;
      bad |= differs("write_kind", exp_r.write_kind, got.write_kind);
      bad |= differs("write_reg", exp_r.write_reg, got.write_reg);
      bad |= differs("write_value", exp_r.write_value, got.write_value);
      bad |= differs("csr_write", exp_r.csr_write, got.csr_write);
      bad |= differs("csr_write_addr", exp_r.csr_write_addr, got.csr_write_addr);
      bad |= differs("csr_write_value", exp_r.csr_write_value, got.csr_write_value);
      bad |= differs("redirect", exp_r.redirect, got.redirect);
      bad |= differs("redirect_pc", exp_r.redirect_pc, got.redirect_pc);
      bad |= differs("btb_taken", exp_r.btb_taken, got.btb_taken);
      bad |= differs("btb_target", exp_r.btb_target, got.btb_target);
      bad |= differs("flush_after", exp_r.flush_after, got.flush_after);
      bad |= differs("is_branch", exp_r.is_branch, got.is_branch);
      if (bad) errors++;
      if (exp_r.redirect) redirects++;
      if (exp_r.csr_write) csr_writes++;
      compared++;
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [6:0]             s_axis_tuser;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [1:0]             m_axis_tuser;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  writeback_checker sb;
  int               idle_pct;
  int               stall_pct;
  int               hold_left;
  int unsigned      cycles;

  riscv_writeback_branch_resolve u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    k;
    it.control_flags = 7'($urandom);
    if ($urandom_range(9) != 0) it.control_flags[FL_ILLEGAL] = 1'b0;
    k = $urandom_range(99);
    if (k < 20)      it.major_opcode = OP_CSR;
    else if (k < 32) it.major_opcode = OP_JAL;
    else if (k < 44) it.major_opcode = OP_JALR;
    else if (k < 74) it.major_opcode = OP_BRANCH;
    else             it.major_opcode = 7'($urandom);
    if (it.major_opcode inside {OP_JAL, OP_JALR, OP_BRANCH} && $urandom_range(4) != 0)
      it.control_flags[FL_BRANCH] = 1'b1;
    it.sub_function = 3'($urandom);
    it.dest_reg     = 5'($urandom);
    case ($urandom_range(3))
      0:       it.alu_result = '0;
      1:       it.alu_result = 64'd1;
      default: it.alu_result = rand64();
    endcase
    it.mem_data = rand64();
    it.instr_pc = ($urandom_range(7) == 0) ? ~64'($urandom_range(15)) : rand64();
    if ($urandom_range(1) == 0) it.branch_offset = 32'($urandom);
    else                        it.branch_offset = 32'($signed($urandom_range(8191)) - 4096);
    it.reorder_index = 5'($urandom);
    it.csr_address   = 12'($urandom);
    it.csr_old       = rand64();
    it.csr_operand   = ($urandom_range(3) == 0) ? '0 : rand64();
    return it;
  endfunction

  function automatic item_t make_item(logic [6:0] flags, logic [6:0] opc, logic [2:0] f3);
    item_t it;
    it = rand_item();
    it.control_flags = flags;
    it.major_opcode  = opc;
    it.sub_function  = f3;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tuser  <= it.control_flags;
    s_axis_tdata  <= {it.csr_operand, it.csr_old, it.csr_address, it.reorder_index,
                      it.branch_offset, it.instr_pc, it.mem_data, it.alu_result,
                      it.dest_reg, it.sub_function, it.major_opcode};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    item_t it;
    it = '1;
    send_item(it);
    it = '0;
    send_item(it);
    for (int f = 0; f < 8; f++) send_item(make_item(~F_ILL, OP_CSR, 3'(f)));
    it = make_item(F_WR, OP_CSR, {1'b0, CSR_OP_RS});
    it.csr_operand = '0;
    send_item(it);
    it = make_item(F_WR, OP_CSR, {1'b1, CSR_OP_RC});
    it.csr_operand = '0;
    send_item(it);
    send_item(make_item(F_BR | F_WR | F_PRED, OP_JAL, 3'($urandom)));
    send_item(make_item(F_BR | F_WR, OP_JALR, 3'($urandom)));
    send_item(make_item(F_BR | F_WR | F_MEM | F_PRED, OP_JALR, 3'($urandom)));
    for (int f = 0; f < 8; f++) begin
      it = make_item(F_BR | ($urandom_range(1) ? F_PRED : 7'd0), OP_BRANCH, 3'(f));
      it.alu_result = 64'($urandom_range(1));
      send_item(it);
    end
    send_item(make_item(F_BR | F_WR | F_PRED, 7'h33, 3'($urandom)));
    send_item(make_item(F_FCSR | F_WR | F_FP | F_MEM, 7'h07, 3'($urandom)));
    it = make_item(F_BR | F_WR, OP_JAL, 3'($urandom));
    it.instr_pc      = '1;
    it.branch_offset = 32'sd4;
    send_item(it);
  endtask

  initial begin
    result_t got;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.write_kind      = m_axis_tuser;
        got.write_reg       = m_axis_tdata[4:0];
        got.write_value     = m_axis_tdata[68:5];
        got.csr_write       = m_axis_tdata[69];
        got.csr_write_addr  = m_axis_tdata[81:70];
        got.csr_write_value = m_axis_tdata[145:82];
        got.redirect        = m_axis_tdata[146];
        got.redirect_pc     = m_axis_tdata[210:147];
        got.btb_taken       = m_axis_tdata[211];
        got.btb_target      = m_axis_tdata[275:212];
        got.flush_after     = m_axis_tdata[280:276];
        got.is_branch       = m_axis_tdata[281];
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    hold_left     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_left = HOLD_CYCLES; end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
      s_axis_tvalid <= 1'b0;
      drain();
    end
    repeat (8) @(posedge clk_i);
    $display("%0d instructions retired, %0d branches/jumps, %0d mispredicts in the model",
             sb.retired, sb.branches, sb.mispredicts);
    $display("%0d results compared (%0d redirects, %0d CSR writes), %0d mismatches",
             sb.compared, sb.redirects, sb.csr_writes, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
